// File: rtl/cl4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cl4_pkg: shared definitions for the character LCD 4-bit driver
// Request codes, register indexes, reset values and the init byte table.
// ----------------------------------------------------------------------------
package cl4_pkg;

  localparam int COUNTER_WIDTH_DEFAULT = 16;
  localparam int CFG_INDEX_WIDTH       = 8;
  localparam int CFG_DATA_WIDTH        = 16;
  localparam int REQ_TYPE_WIDTH        = 3;
  localparam int INIT_STEP_WIDTH       = 3;

  localparam logic [REQ_TYPE_WIDTH-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_TYPE_WIDTH-1:0] REQ_COMMAND = 3'd1;
  localparam logic [REQ_TYPE_WIDTH-1:0] REQ_DATA    = 3'd2;
  localparam logic [REQ_TYPE_WIDTH-1:0] REQ_INIT    = 3'd3;
  localparam logic [REQ_TYPE_WIDTH-1:0] REQ_CLEAR   = 3'd4;
  localparam logic [REQ_TYPE_WIDTH-1:0] REQ_SET_POS = 3'd5;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NIBBLE_WAIT  = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POWERUP_WAIT = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLEAR_WAIT   = 8'd3;

  localparam logic [7:0]  PULSE_WIDTH_RESET  = 8'd1;
  localparam logic [15:0] NIBBLE_WAIT_RESET  = 16'd100;
  localparam logic [15:0] POWERUP_WAIT_RESET = 16'd50000;
  localparam logic [15:0] CLEAR_WAIT_RESET   = 16'd2000;

  localparam logic [7:0] CMD_CLEAR = 8'h01;

  typedef struct packed {
    logic [REQ_TYPE_WIDTH-1:0] req_type;
    logic [7:0]                byte_value;
    logic [5:0]                column;
    logic                      row;
  } req_t;

  typedef struct packed {
    logic [3:0] lcd_nibble;
    logic       lcd_rs;
    logic       lcd_en;
    logic       busy_res;
    logic       accepted;
  } res_t;

  function automatic logic [7:0] init_byte(input logic [INIT_STEP_WIDTH-1:0] idx);
    logic [7:0] b;
    begin
      case (idx)
        3'd0:    b = 8'h33;
        3'd1:    b = 8'h32;
        3'd2:    b = 8'h28;
        3'd3:    b = 8'h0C;
        3'd4:    b = 8'h01;
        default: b = 8'h01;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/cl4_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cl4_if: channel interfaces of the character LCD 4-bit driver
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface cl4_req_if;
  logic                                valid;
  logic                                ready;
  logic [cl4_pkg::REQ_TYPE_WIDTH-1:0]  req_type;
  logic [7:0]                          byte_value;
  logic [5:0]                          column;
  logic                                row;

  modport source (output valid, req_type, byte_value, column, row, input ready);
  modport sink (input valid, req_type, byte_value, column, row, output ready);
endinterface

interface cl4_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] lcd_nibble;
  logic       lcd_rs;
  logic       lcd_en;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, lcd_nibble, lcd_rs, lcd_en, busy_res, accepted,
                  input ready);
  modport sink (input valid, lcd_nibble, lcd_rs, lcd_en, busy_res, accepted,
                output ready);
endinterface

interface cl4_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cl4_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [cl4_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/cl4_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cl4_core: sequencer of the character LCD 4-bit driver
// Holds the timing registers, the phase and the tick counter, and computes
// the pin levels after each tick or request.
// ----------------------------------------------------------------------------
module cl4_core #(
  parameter int COUNTER_WIDTH = cl4_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  cl4_cfg_if.sink            cfg,
  input  wire                req_fire,
  input  cl4_pkg::req_t      req_in,
  output cl4_pkg::res_t      res_out
);
  import cl4_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PWR  = 3'd1;
  localparam logic [2:0] PH_HI1  = 3'd2;
  localparam logic [2:0] PH_W1   = 3'd3;
  localparam logic [2:0] PH_HI2  = 3'd4;
  localparam logic [2:0] PH_W2   = 3'd5;
  localparam logic [2:0] PH_LONG = 3'd6;

  logic [7:0]  pulse_width;
  logic [15:0] nibble_wait;
  logic [15:0] powerup_wait;
  logic [15:0] clear_wait;

  logic [2:0]                 phase, phase_next;
  logic [COUNTER_WIDTH-1:0]   wait_count, wait_count_next;
  logic [7:0]                 held_byte, held_byte_next;
  logic                       held_rs, held_rs_next;
  logic [INIT_STEP_WIDTH-1:0] init_step, init_step_next;
  logic                       long_pending, long_pending_next;
  logic [3:0]                 pin_nibble, pin_nibble_next;
  logic                       pin_en, pin_en_next;
  logic                       acc;

  logic       do_start;
  logic [7:0] start_byte;
  logic       start_rs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_width  <= PULSE_WIDTH_RESET;
      nibble_wait  <= NIBBLE_WAIT_RESET;
      powerup_wait <= POWERUP_WAIT_RESET;
      clear_wait   <= CLEAR_WAIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PULSE_WIDTH:  pulse_width  <= cfg.data[7:0];
        REG_NIBBLE_WAIT:  nibble_wait  <= cfg.data;
        REG_POWERUP_WAIT: powerup_wait <= cfg.data;
        REG_CLEAR_WAIT:   clear_wait   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    held_byte_next    = held_byte;
    held_rs_next      = held_rs;
    init_step_next    = init_step;
    long_pending_next = long_pending;
    pin_nibble_next   = pin_nibble;
    pin_en_next       = pin_en;
    acc               = 1'b0;
    do_start          = 1'b0;
    start_byte        = 8'h00;
    start_rs          = 1'b0;

    if (req_in.req_type == REQ_TICK) begin
      if (phase != PH_IDLE) begin
        if (wait_count <= COUNTER_WIDTH'(1)) begin
          wait_count_next = '0;
          unique case (phase)
            PH_LONG: phase_next = PH_IDLE;
            PH_PWR: begin
              init_step_next = INIT_STEP_WIDTH'(1);
              do_start       = 1'b1;
              start_byte     = init_byte(INIT_STEP_WIDTH'(0));
            end
            PH_HI1: begin
              pin_en_next     = 1'b0;
              phase_next      = PH_W1;
              wait_count_next = held_rs ? COUNTER_WIDTH'(1) : COUNTER_WIDTH'(nibble_wait);
            end
            PH_W1: begin
              pin_nibble_next = held_byte[3:0];
              pin_en_next     = 1'b1;
              phase_next      = PH_HI2;
              wait_count_next = COUNTER_WIDTH'(pulse_width);
            end
            PH_HI2: begin
              pin_en_next     = 1'b0;
              phase_next      = PH_W2;
              wait_count_next = COUNTER_WIDTH'(nibble_wait);
            end
            PH_W2: begin
              if (init_step >= INIT_STEP_WIDTH'(1) && init_step <= INIT_STEP_WIDTH'(4)) begin
                init_step_next = init_step + INIT_STEP_WIDTH'(1);
                do_start       = 1'b1;
                start_byte     = init_byte(init_step);
              end else begin
                init_step_next = '0;
                if (long_pending) begin
                  long_pending_next = 1'b0;
                  phase_next        = PH_LONG;
                  wait_count_next   = COUNTER_WIDTH'(clear_wait);
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end else begin
          wait_count_next = wait_count - COUNTER_WIDTH'(1);
        end
      end
    end else if (phase == PH_IDLE && req_in.req_type <= REQ_SET_POS) begin
      acc               = 1'b1;
      long_pending_next = 1'b0;
      init_step_next    = '0;
      case (req_in.req_type)
        REQ_COMMAND: begin
          do_start   = 1'b1;
          start_byte = req_in.byte_value;
        end
        REQ_DATA: begin
          do_start   = 1'b1;
          start_byte = req_in.byte_value;
          start_rs   = 1'b1;
        end
        REQ_INIT: begin
          held_rs_next      = 1'b0;
          pin_en_next       = 1'b0;
          long_pending_next = 1'b1;
          phase_next        = PH_PWR;
          wait_count_next   = COUNTER_WIDTH'(powerup_wait);
        end
        REQ_CLEAR: begin
          long_pending_next = 1'b1;
          do_start          = 1'b1;
          start_byte        = CMD_CLEAR;
        end
        default: begin
          do_start   = 1'b1;
          start_byte = {1'b1, req_in.row, req_in.column};
        end
      endcase
    end

    if (do_start) begin
      held_byte_next  = start_byte;
      held_rs_next    = start_rs;
      pin_nibble_next = start_byte[7:4];
      pin_en_next     = 1'b1;
      phase_next      = PH_HI1;
      wait_count_next = COUNTER_WIDTH'(pulse_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_count   <= '0;
      held_byte    <= 8'h00;
      held_rs      <= 1'b0;
      init_step    <= '0;
      long_pending <= 1'b0;
      pin_nibble   <= 4'h0;
      pin_en       <= 1'b0;
    end else if (req_fire) begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      held_byte    <= held_byte_next;
      held_rs      <= held_rs_next;
      init_step    <= init_step_next;
      long_pending <= long_pending_next;
      pin_nibble   <= pin_nibble_next;
      pin_en       <= pin_en_next;
    end
  end

  always_comb begin
    res_out.lcd_nibble = pin_nibble_next;
    res_out.lcd_rs     = held_rs_next;
    res_out.lcd_en     = pin_en_next;
    res_out.busy_res   = (phase_next != PH_IDLE);
    res_out.accepted   = acc;
  end

endmodule
`default_nettype wire

// File: rtl/char_lcd_4bit_interface.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface: character LCD driver in 4-bit mode
// Each accepted tick or request yields a result, registered into the result
// buffer. Requests are accepted one per cycle while the buffer has room; a
// two-entry result buffer keeps requests flowing while a result waits, and
// ready drops when both entries are full. Reset restores the timing registers
// to their defaults, idles the sequencer and empties the result buffer.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface #(
  parameter int COUNTER_WIDTH = cl4_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  cl4_req_if.sink      req,
  cl4_res_if.source    res,
  cl4_cfg_if.sink      cfg
);
  import cl4_pkg::*;

  req_t req_in;
  res_t core_res;
  res_t main_res;
  res_t skid_res;
  logic main_valid;
  logic skid_valid;
  logic push;
  logic pop;

  assign req_in.req_type   = req.req_type;
  assign req_in.byte_value = req.byte_value;
  assign req_in.column     = req.column;
  assign req_in.row        = req.row;

  assign req.ready = !skid_valid;
  assign push      = req.valid && !skid_valid;
  assign pop       = main_valid && res.ready;

  cl4_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_fire (push),
    .req_in   (req_in),
    .res_out  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !main_valid) begin
      main_res <= skid_valid ? skid_res : core_res;
    end else if (push) begin
      skid_res <= core_res;
    end
  end

  assign res.valid      = main_valid;
  assign res.lcd_nibble = main_res.lcd_nibble;
  assign res.lcd_rs     = main_res.lcd_rs;
  assign res.lcd_en     = main_res.lcd_en;
  assign res.busy_res   = main_res.busy_res;
  assign res.accepted   = main_res.accepted;

endmodule
`default_nettype wire
